// ===== sv/wpm_pkg.sv =====
// Shared constants and types for the wildcard pattern matcher.
package wpm_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_MAX_DEFAULT = 32;

    // Pattern bytes with special meaning
    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    // Input beat operation codes
    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_BEGIN  = 2'd2,
        ACT_TEXT   = 2'd3
    } action_t;

endpackage

// ===== sv/wildcard_pattern_matcher.sv =====
// Top level of the wildcard pattern matcher: input register, state, result register.
//
// Usage: drive beats on the input channel (in_valid/in_ready, action, symbol).
// A clear beat empties the pattern and the overflow flag; append beats load the
// pattern one byte at a time ('?' matches any byte, '*' any run). A begin beat
// starts a text and each text beat feeds one text byte. Begin and text beats
// each return one result beat (matched, no_live_position, pattern_overflow) on
// the output channel (out_valid/out_ready); clear and append beats return none.
// The accepted beat sits in the input register while the advance plus star closure
// network settles, and the result register loads when the beat advances.
// Throughput is one beat per cycle while the receiver does not stall the output.
// Reset empties the pattern, the position set and the overflow flag and drops
// any beat in flight; pattern storage is not cleared. When the receiver stalls,
// the result register holds; the input register keeps accepting until it holds
// a result-producing beat that cannot move, then in_ready drops.
module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       no_live_position,
    output logic       pattern_overflow
);

    localparam int W     = PATTERN_MAX + 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // Input stage
    logic                in_full_reg;
    wpm_pkg::action_t    action_reg;
    logic [7:0]          symbol_reg;

    // Block state
    logic [7:0]          pattern_reg [PATTERN_MAX];
    logic [LEN_W-1:0]    length_reg;
    logic [LEN_W-1:0]    length_next;
    logic [W-1:0]        active_reg;
    logic [W-1:0]        active_next;
    logic                overflow_reg;
    logic                overflow_next;

    // Result stage
    logic                out_valid_reg;
    logic                matched_reg;
    logic                no_live_reg;
    logic                overflow_out_reg;

    logic                has_result;
    logic                advance;
    logic [W-1:0]        step_active;

    // Move the held beat when its result, if any, has room
    assign has_result = (action_reg == wpm_pkg::ACT_BEGIN) || (action_reg == wpm_pkg::ACT_TEXT);
    assign advance    = in_full_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready   = !in_full_reg || advance;

    wpm_core #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_core (
        .active      (active_reg),
        .pattern     (pattern_reg),
        .length      (length_reg),
        .is_begin    (action_reg == wpm_pkg::ACT_BEGIN),
        .symbol      (symbol_reg),
        .next_active (step_active)
    );

    // Next state for the held beat
    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        active_next   = active_reg;
        case (action_reg)
            wpm_pkg::ACT_CLEAR:
            begin
                length_next   = '0;
                overflow_next = 1'b0;
                active_next   = '0;
            end
            wpm_pkg::ACT_APPEND:
            begin
                if (length_reg < LEN_W'(PATTERN_MAX))
                begin
                    length_next = length_reg + LEN_W'(1);
                end
                else
                begin
                    overflow_next = 1'b1;
                end
                active_next = '0;
            end
            wpm_pkg::ACT_BEGIN,
            wpm_pkg::ACT_TEXT:
            begin
                active_next = step_active;
            end
            default:
            begin
                active_next = active_reg;
            end
        endcase
    end

    // Capture input beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            action_reg <= wpm_pkg::action_t'(action);
            symbol_reg <= symbol;
        end
    end

    // Update pattern length, position set and overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            active_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else if (advance)
        begin
            length_reg   <= length_next;
            active_reg   <= active_next;
            overflow_reg <= overflow_next;
        end
    end

    // Store appended pattern bytes while there is room
    always_ff @(posedge clk)
    begin
        if (advance && action_reg == wpm_pkg::ACT_APPEND
            && length_reg < LEN_W'(PATTERN_MAX))
        begin
            pattern_reg[length_reg[IDX_W-1:0]] <= symbol_reg;
        end
    end

    // Result register: load on a result-producing beat, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            matched_reg      <= active_next[length_reg];
            no_live_reg      <= (active_next == '0);
            overflow_out_reg <= overflow_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign no_live_position = no_live_reg;
    assign pattern_overflow = overflow_out_reg;

endmodule

// ===== sv/wpm_core.sv =====
// Next active-position set: byte advance followed by a star closure prefix network.
module wpm_core #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEFAULT,
    localparam int W = PATTERN_MAX + 1,
    localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
    input  logic [W-1:0]     active,
    input  logic [7:0]       pattern [PATTERN_MAX],
    input  logic [LEN_W-1:0] length,
    input  logic             is_begin,
    input  logic [7:0]       symbol,
    output logic [W-1:0]     next_active
);

    localparam int LEVELS = $clog2(W);

    logic [PATTERN_MAX-1:0] pos_valid;
    logic [PATTERN_MAX-1:0] pos_star;
    logic [W-1:0]           seed;
    logic [W-1:0]           gen_l  [LEVELS+1];
    logic [W-1:0]           prop_l [LEVELS+1];

    // Flag live positions and stars
    always_comb
    begin
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            pos_valid[j] = LEN_W'(j) < length;
            pos_star[j]  = pos_valid[j] && (pattern[j] == wpm_pkg::STAR_BYTE);
        end
    end

    // Advance each live position by one text byte, or seed position zero on begin
    always_comb
    begin
        seed = '0;
        if (is_begin)
        begin
            seed[0] = 1'b1;
        end
        else
        begin
            for (int j = 0; j < PATTERN_MAX; j++)
            begin
                if (active[j] && pos_valid[j])
                begin
                    if (pattern[j] == wpm_pkg::STAR_BYTE)
                    begin
                        seed[j] = 1'b1;
                    end
                    else if (pattern[j] == wpm_pkg::ANY_BYTE || pattern[j] == symbol)
                    begin
                        seed[j+1] = 1'b1;
                    end
                end
            end
        end
    end

    // Close over stars: a set bit in front of a star also sets the next bit.
    // Carry-style recurrence c[k] = g[k] | (p[k] & c[k-1]), solved as a log-depth prefix.
    always_comb
    begin
        gen_l[0]     = seed;
        prop_l[0]    = '0;
        for (int k = 1; k < W; k++)
        begin
            prop_l[0][k] = pos_star[k-1];
        end
        for (int lv = 0; lv < LEVELS; lv++)
        begin
            gen_l[lv+1]  = gen_l[lv];
            prop_l[lv+1] = prop_l[lv];
            for (int k = 0; k < W; k++)
            begin
                if (k >= (1 << lv))
                begin
                    gen_l[lv+1][k]  = gen_l[lv][k]
                                    | (prop_l[lv][k] & gen_l[lv][k - (1 << lv)]);
                    prop_l[lv+1][k] = prop_l[lv][k] & prop_l[lv][k - (1 << lv)];
                end
            end
        end
        next_active = gen_l[LEVELS];
    end

endmodule

// ===== tb/wpm_checker.sv =====
// Checker for the wildcard pattern matcher: tracks pattern and positions, scores result beats.
module wpm_checker #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [1:0] action,
    input  logic [7:0] symbol,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       matched,
    input  logic       no_live_position,
    input  logic       pattern_overflow,
    output int         errors,
    output int         reports_due,
    output int         reports_checked,
    output int         full_matches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic hit;
        logic dead;
        logic overflow;
    } match_report_t;

    logic [7:0]           pat_store [PATTERN_MAX];
    int unsigned          pat_len;
    logic [PATTERN_MAX:0] live_set;
    logic                 overflow_seen;
    match_report_t        reports_q [$];

    // A live position in front of a star also makes the next one live (empty run)
    function automatic logic [PATTERN_MAX:0] close_stars(input logic [PATTERN_MAX:0] set);
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (j < pat_len && set[j] && pat_store[j] == wpm_pkg::STAR_BYTE)
                set[j+1] = 1'b1;
        end
        return set;
    endfunction

    // Step every live position over one text byte
    function automatic logic [PATTERN_MAX:0] advance_positions(input logic [PATTERN_MAX:0] set,
                                                               input logic [7:0] ch);
        logic [PATTERN_MAX:0] next;
        next = '0;
        for (int j = 0; j < PATTERN_MAX; j++)
        begin
            if (j < pat_len && set[j])
            begin
                if (pat_store[j] == wpm_pkg::STAR_BYTE)
                    next[j] = 1'b1;
                else if (pat_store[j] == wpm_pkg::ANY_BYTE || pat_store[j] == ch)
                    next[j+1] = 1'b1;
            end
        end
        return close_stars(next);
    endfunction

    initial
    begin
        errors          = 0;
        reports_due     = 0;
        reports_checked = 0;
        full_matches    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        match_report_t due;
        if (!rst_n)
        begin
            pat_len       = 0;
            live_set      = '0;
            overflow_seen = 1'b0;
            reports_q.delete();
            reports_due   = 0;
        end
        else
        begin
            // Score the result beat first so a beat accepted this edge cannot mask it
            if (out_valid && out_ready)
            begin
                if (reports_q.size() == 0)
                begin
                    errors++;
                    $display("%t: unexpected result beat matched=%b no_live=%b overflow=%b",
                             $time, matched, no_live_position, pattern_overflow);
                end
                else
                begin
                    due = reports_q.pop_front();
                    reports_checked++;
                    if (matched === 1'b1)
                        full_matches++;
                    if (matched !== due.hit)
                    begin
                        errors++;
                        $display("%t: matched expected %b actual %b",
                                 $time, due.hit, matched);
                    end
                    if (no_live_position !== due.dead)
                    begin
                        errors++;
                        $display("%t: no_live_position expected %b actual %b",
                                 $time, due.dead, no_live_position);
                    end
                    if (pattern_overflow !== due.overflow)
                    begin
                        errors++;
                        $display("%t: pattern_overflow expected %b actual %b",
                                 $time, due.overflow, pattern_overflow);
                    end
                end
            end

            // Apply the accepted input beat to the tracked state
            if (in_valid && in_ready)
            begin
                case (wpm_pkg::action_t'(action))
                    wpm_pkg::ACT_CLEAR:
                    begin
                        pat_len       = 0;
                        overflow_seen = 1'b0;
                        live_set      = '0;
                    end
                    wpm_pkg::ACT_APPEND:
                    begin
                        if (pat_len < PATTERN_MAX)
                        begin
                            pat_store[pat_len] = symbol;
                            pat_len++;
                        end
                        else
                            overflow_seen = 1'b1;
                        live_set = '0;
                    end
                    wpm_pkg::ACT_BEGIN:
                        live_set = close_stars({{PATTERN_MAX{1'b0}}, 1'b1});
                    default:
                        live_set = advance_positions(live_set, symbol);
                endcase
                if (wpm_pkg::action_t'(action) == wpm_pkg::ACT_BEGIN
                    || wpm_pkg::action_t'(action) == wpm_pkg::ACT_TEXT)
                begin
                    due.hit      = live_set[pat_len];
                    due.dead     = (live_set == '0);
                    due.overflow = overflow_seen;
                    reports_q.push_back(due);
                end
            end
            reports_due = reports_q.size();
        end
    end

endmodule

// ===== tb/tb_wildcard_pattern_matcher.sv =====
// Testbench top for the wildcard pattern matcher: clock, reset, stimulus and verdict.
module tb_wildcard_pattern_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PATTERN_CAP = wpm_pkg::PATTERN_MAX_DEFAULT;
    localparam int BEAT_TARGET = 2000;
    localparam int CYCLE_LIMIT = 500000;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [1:0] action    = wpm_pkg::ACT_CLEAR;
    logic [7:0] symbol    = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       matched;
    logic       no_live_position;
    logic       pattern_overflow;

    int errors;
    int reports_due;
    int reports_checked;
    int full_matches;

    int beats_sent  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    logic [7:0] pat_q [$];
    logic [7:0] txt_q [$];
    logic [7:0] alphabet [6] = '{"a", "b", "c", wpm_pkg::STAR_BYTE, wpm_pkg::ANY_BYTE, 8'h00};

    wildcard_pattern_matcher #(.PATTERN_MAX(PATTERN_CAP)) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .symbol           (symbol),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .matched          (matched),
        .no_live_position (no_live_position),
        .pattern_overflow (pattern_overflow)
    );

    wpm_checker #(.PATTERN_MAX(PATTERN_CAP)) checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .symbol           (symbol),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .matched          (matched),
        .no_live_position (no_live_position),
        .pattern_overflow (pattern_overflow),
        .errors           (errors),
        .reports_due      (reports_due),
        .reports_checked  (reports_checked),
        .full_matches     (full_matches)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d result beats outstanding",
                     cycle_count, reports_due);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Stall the result channel, switching between steady, random and periodic stalls
    initial
    begin
        int mode;
        int span;
        int tick;
        tick = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 9) < 7);
                    2:       out_ready <= ($urandom_range(0, 9) < 3);
                    default: out_ready <= ((tick % 11) >= 4);
                endcase
            end
        end
    end

    // Hold one beat until accepted, then either keep the burst going or idle a while
    task automatic send_beat(input wpm_pkg::action_t op, input logic [7:0] sym);
        in_valid <= 1'b1;
        action   <= op;
        symbol   <= sym;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Replace the stored pattern with pat_q
    task automatic load_pattern();
        send_beat(wpm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
        foreach (pat_q[i])
            send_beat(wpm_pkg::ACT_APPEND, pat_q[i]);
    endtask

    // Run txt_q as one text
    task automatic put_text();
        send_beat(wpm_pkg::ACT_BEGIN, 8'($urandom_range(0, 255)));
        foreach (txt_q[i])
            send_beat(wpm_pkg::ACT_TEXT, txt_q[i]);
    endtask

    initial
    begin
        int roll;
        int plen;
        int lim;
        bit have_pattern;
        logic [7:0] pb;

        have_pattern = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: text without begin, empty pattern, star against a text star
        send_beat(wpm_pkg::ACT_TEXT, 8'h00);
        send_beat(wpm_pkg::ACT_BEGIN, 8'hFF);
        send_beat(wpm_pkg::ACT_TEXT, 8'hFF);
        send_beat(wpm_pkg::ACT_CLEAR, 8'hFF);
        send_beat(wpm_pkg::ACT_APPEND, wpm_pkg::STAR_BYTE);
        send_beat(wpm_pkg::ACT_BEGIN, 8'h00);
        send_beat(wpm_pkg::ACT_TEXT, wpm_pkg::STAR_BYTE);
        send_beat(wpm_pkg::ACT_TEXT, 8'h00);
        // Directed: pattern change mid-text and the need for a fresh begin
        send_beat(wpm_pkg::ACT_CLEAR, 8'h00);
        send_beat(wpm_pkg::ACT_APPEND, "a");
        send_beat(wpm_pkg::ACT_APPEND, wpm_pkg::ANY_BYTE);
        send_beat(wpm_pkg::ACT_TEXT, "a");
        send_beat(wpm_pkg::ACT_BEGIN, 8'h00);
        send_beat(wpm_pkg::ACT_TEXT, "a");
        send_beat(wpm_pkg::ACT_APPEND, "z");
        send_beat(wpm_pkg::ACT_TEXT, "b");
        send_beat(wpm_pkg::ACT_BEGIN, 8'h00);
        send_beat(wpm_pkg::ACT_TEXT, "a");
        send_beat(wpm_pkg::ACT_TEXT, 8'hFF);
        send_beat(wpm_pkg::ACT_TEXT, "x");
        send_beat(wpm_pkg::ACT_TEXT, "y");
        // Directed: fill the pattern and push one byte past capacity
        pat_q.delete();
        repeat (PATTERN_CAP - 1) pat_q.push_back(wpm_pkg::STAR_BYTE);
        pat_q.push_back(wpm_pkg::ANY_BYTE);
        pat_q.push_back("Z");
        load_pattern();
        txt_q = '{"q"};
        put_text();

        // Random: mostly pattern loads and texts derived from them, some noise
        while (beats_sent < BEAT_TARGET)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                send_beat(wpm_pkg::action_t'($urandom_range(0, 3)),
                          8'($urandom_range(0, 255)));
            else if (roll < 28 || !have_pattern)
            begin
                pat_q.delete();
                plen = ($urandom_range(0, 9) == 0) ? $urandom_range(PATTERN_CAP - 4,
                                                                     PATTERN_CAP + 4)
                                                   : $urandom_range(0, 8);
                repeat (plen)
                begin
                    roll = $urandom_range(0, 9);
                    if (roll < 5)
                        pb = alphabet[$urandom_range(0, 2)];
                    else if (roll < 7)
                        pb = wpm_pkg::STAR_BYTE;
                    else if (roll < 9)
                        pb = wpm_pkg::ANY_BYTE;
                    else
                        pb = 8'($urandom_range(0, 255));
                    pat_q.push_back(pb);
                end
                load_pattern();
                have_pattern = 1'b1;
            end
            else
            begin
                // Build a text that fits the pattern, then maybe corrupt it
                txt_q.delete();
                lim = (pat_q.size() < PATTERN_CAP) ? pat_q.size() : PATTERN_CAP;
                for (int i = 0; i < lim; i++)
                begin
                    if (pat_q[i] == wpm_pkg::STAR_BYTE)
                    begin
                        repeat ($urandom_range(0, 3))
                            txt_q.push_back(($urandom_range(0, 9) < 8)
                                            ? alphabet[$urandom_range(0, 5)]
                                            : 8'($urandom_range(0, 255)));
                    end
                    else if (pat_q[i] == wpm_pkg::ANY_BYTE)
                        txt_q.push_back(8'($urandom_range(0, 255)));
                    else
                        txt_q.push_back(pat_q[i]);
                end
                if ($urandom_range(0, 3) == 0 && txt_q.size() > 0)
                    txt_q[$urandom_range(0, txt_q.size() - 1)] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 5) == 0)
                    txt_q.push_back(alphabet[$urandom_range(0, 5)]);
                if ($urandom_range(0, 7) == 0 && txt_q.size() > 0)
                    void'(txt_q.pop_back());
                put_text();
            end
        end

        // Drain: wait for every predicted result, then for any stray beats
        in_valid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Drove %0d input beats; scored %0d result beats, %0d of them full matches.",
                 beats_sent, reports_checked, full_matches);
        $display("%s", {"Covered empty and full patterns, overflow, ",
                        "texts without begin and mid-text loads."});
        if (errors == 0 && reports_due == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
